// ===== rtl/core/lrukv_pkg.sv =====
// lrukv_pkg: request/response payloads, cell-chain structs and constants
// for the LRU key-value cache. No dependencies.
package lrukv_pkg;

    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int CAPACITY_DEF = 4;

    // action codes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    // result on a get that misses
    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                    action;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
    } t_rsp;

    // rippled from cell to cell, lowest index first
    typedef struct packed {
        logic                    found;      // a lower cell already matched
        logic                    free_seen;  // a lower cell is already free
        logic signed [VAL_W-1:0] hit_value;  // value of the first match
    } t_chain;

    // fed back to every cell from the end of the chain
    typedef struct packed {
        logic hit;
        logic any_free;
        logic is_set;
    } t_bcast;

endpackage

// ===== rtl/core/lrukv_cell.sv =====
// lrukv_cell: one cache entry (valid, key, value, recency rank) with its
// link in the match/free priority chain. Depends on lrukv_pkg.
module lrukv_cell #(
    parameter int RANK_W = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  lrukv_pkg::t_req       i_req,
    input  lrukv_pkg::t_chain     i_chain,
    input  logic [RANK_W-1:0]     i_hit_rank,
    output lrukv_pkg::t_chain     o_chain,
    output logic [RANK_W-1:0]     o_hit_rank,
    input  lrukv_pkg::t_bcast     i_bc,
    input  logic [RANK_W-1:0]     i_touch_rank
);
    import lrukv_pkg::*;

    logic                    r_valid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [VAL_W-1:0] r_value;
    logic [RANK_W-1:0]       r_rank;

    logic match, sel_hit, first_free;

    assign match      = r_valid && (r_key == i_req.key);
    assign sel_hit    = match && !i_chain.found;
    assign first_free = !r_valid && !i_chain.free_seen;

    assign o_chain.found     = i_chain.found | match;
    assign o_chain.free_seen = i_chain.free_seen | !r_valid;
    assign o_chain.hit_value = sel_hit ? r_value : i_chain.hit_value;
    assign o_hit_rank        = sel_hit ? r_rank : i_hit_rank;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else if (i_en) begin
            if (i_bc.hit) begin
                if (sel_hit) begin
                    r_rank <= '0;
                end else if (r_valid && (r_rank < i_touch_rank)) begin
                    r_rank <= r_rank + 1'b1;
                end
            end else if (i_bc.is_set) begin
                if (i_bc.any_free) begin
                    if (first_free) begin
                        r_valid <= 1'b1;
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end else if (r_rank == i_touch_rank) begin
                    r_rank <= '0;                  // victim slot reused
                end else begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_bc.hit) begin
                if (sel_hit && i_bc.is_set) begin
                    r_value <= i_req.value;
                end
            end else if (i_bc.is_set) begin
                if ((i_bc.any_free && first_free) ||
                    (!i_bc.any_free && (r_rank == i_touch_rank))) begin
                    r_key   <= i_req.key;
                    r_value <= i_req.value;
                end
            end
        end
    end

endmodule

// ===== rtl/core/lru_key_value_cache.sv =====
// lru_key_value_cache: top level, a chain of lrukv_cell entries plus the
// response register. Depends on lrukv_pkg and lrukv_cell.
//
// Fully associative key-value store of CAPACITY entries with least-recently-
// used replacement. Each request is a get or a set. When a request is taken,
// every cell compares its key at once, a priority chain from cell 0
// upward picks the lowest matching entry and the lowest free entry, and all
// ranks update on the same clock edge. The response appears in the output
// register on the next cycle. Throughput is one request per cycle; o_ready
// drops only while a response sits unaccepted, since the single output
// register is the only place a response can wait. Ranks run 0 (most recent)
// to n-1 over the n valid entries; when full the victim is the entry at rank
// CAPACITY-1. Valid marks clear at reset, so no clearing pass is needed.
module lru_key_value_cache #(
    parameter int CAPACITY = lrukv_pkg::CAPACITY_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // request channel
    input  logic            i_valid,
    output logic            o_ready,
    input  lrukv_pkg::t_req i_req,
    // response channel
    output logic            o_valid,
    input  logic            i_ready,
    output lrukv_pkg::t_rsp o_rsp
);
    import lrukv_pkg::*;

    localparam int RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic              req_acc;
    t_chain            chain     [CAPACITY+1];
    logic [RANK_W-1:0] hit_rank  [CAPACITY+1];
    t_bcast            bc;
    logic [RANK_W-1:0] touch_rank;
    t_rsp              n_rsp;

    logic r_out_valid;
    t_rsp r_rsp;

    // a new request may enter whenever the response slot is empty or draining
    assign o_ready = !r_out_valid || i_ready;
    assign req_acc = i_valid && o_ready;

    assign chain[0]    = '{found: 1'b0, free_seen: 1'b0, hit_value: '0};
    assign hit_rank[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            lrukv_cell #(
                .RANK_W (RANK_W)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_en         (req_acc),
                .i_req        (i_req),
                .i_chain      (chain[g]),
                .i_hit_rank   (hit_rank[g]),
                .o_chain      (chain[g+1]),
                .o_hit_rank   (hit_rank[g+1]),
                .i_bc         (bc),
                .i_touch_rank (touch_rank)
            );
        end
    endgenerate

    // end of chain fed back to every cell
    assign bc.hit      = chain[CAPACITY].found;
    assign bc.any_free = chain[CAPACITY].free_seen;
    assign bc.is_set   = (i_req.action == ACT_SET);

    // hit: ranks below the touched one shift up; full miss: victim is the
    // oldest rank, and everything else shifts up
    assign touch_rank = bc.hit ? hit_rank[CAPACITY] : RANK_W'(CAPACITY - 1);

    always_comb begin
        n_rsp.hit        = bc.hit;
        n_rsp.read_value = '0;
        n_rsp.evicted    = 1'b0;
        if (!bc.is_set) begin
            n_rsp.read_value = bc.hit ? chain[CAPACITY].hit_value : MISS_VALUE;
        end else begin
            n_rsp.evicted = !bc.hit && !bc.any_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== rtl/core/lrukv_chk.sv =====
// lrukv_chk: port-level checks for lru_key_value_cache, bound to the top.
// Depends on lrukv_pkg.
module lrukv_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input lrukv_pkg::t_req i_req,
    input logic            o_valid,
    input logic            i_ready,
    input lrukv_pkg::t_rsp o_rsp
);
    import lrukv_pkg::*;

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // every accepted request gives a response next cycle
    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> o_valid)
        else $error("accepted request without response");

    // an eviction only comes from a set on an absent key
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.evicted |-> !o_rsp.hit && o_rsp.read_value == '0)
        else $error("eviction reported with hit or read data");

    // a get straight after a set of the same key hits and returns the value
    a_set_then_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req.action == ACT_SET) ##1
        (i_valid && o_ready && i_req.action == ACT_GET &&
         i_req.key == $past(i_req.key))
        |=> o_rsp.hit && o_rsp.read_value == $past(i_req.value, 2))
        else $error("get after set did not return stored value");

endmodule

bind lru_key_value_cache lrukv_chk u_lrukv_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_req   (i_req),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

// ===== verif/lru_key_value_cache_test.sv =====
// lru_key_value_cache_test: self-checking bench for the LRU key-value cache.
// A directed table, then random gets and sets over a small rotating key pool, are
// checked against an LRU predictor. Depends on lrukv_pkg and lru_key_value_cache.
module lru_key_value_cache_test;
    import lrukv_pkg::*;

    localparam int  CAPACITY     = CAPACITY_DEF;
    localparam int  RANDOM_REQS  = 900;
    localparam int  HOLD_CYCLES  = 300;     // long receiver stall, fills the block
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  POOL_SIZE    = 6;       // > CAPACITY, so evictions happen
    localparam bit  TYPED        = 1'b1;
    localparam bit  PREDICTED    = 1'b0;

    typedef struct packed {
        t_req req;
        logic typed;    // expectation given in the table, not by the predictor
        t_rsp rsp;
    } t_plan_row;

    // Directed part. Typed rows are read straight off the replacement rules.
    t_plan_row plan [] = '{
        // empty store: every get misses
        '{'{ACT_GET, 32'h0000_0000, 32'h0000_0000}, TYPED, '{1'b0, MISS_VALUE, 1'b0}},
        '{'{ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF}, TYPED, '{1'b0, MISS_VALUE, 1'b0}},
        // fill slots 0..3 with the key extremes
        '{'{ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF}, TYPED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000}, TYPED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'h0000_0000, 32'h0000_0000}, TYPED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, TYPED, '{1'b0, 32'h0, 1'b0}},
        // touch the oldest, so the second oldest becomes the victim
        '{'{ACT_GET, 32'h8000_0000, 32'h0000_0000}, TYPED, '{1'b1, 32'h7FFF_FFFF, 1'b0}},
        '{'{ACT_SET, 32'h0000_0005, 32'h0000_0037}, TYPED, '{1'b0, 32'h0, 1'b1}},
        '{'{ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000}, TYPED, '{1'b0, MISS_VALUE, 1'b0}},
        // update in place
        '{'{ACT_SET, 32'h0000_0000, 32'h1234_5678}, TYPED, '{1'b1, 32'h0, 1'b0}},
        '{'{ACT_GET, 32'h0000_0000, 32'h0000_0000}, TYPED, '{1'b1, 32'h1234_5678, 1'b0}},
        // a hit whose stored value looks like a miss
        '{'{ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000}, TYPED, '{1'b1, 32'hFFFF_FFFF, 1'b0}},
        '{'{ACT_SET, 32'hFFFF_FFFF, 32'h0000_0000}, TYPED, '{1'b1, 32'h0, 1'b0}},
        // back-to-back evictions and gets with a junk value field
        '{'{ACT_SET, 32'h0000_0007, 32'h0000_004D}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'h0000_0008, 32'h0000_0058}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_GET, 32'h0000_0005, 32'hDEAD_BEEF}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_GET, 32'h0000_0007, 32'hFFFF_FFFF}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'h8000_0000, 32'h0000_0001}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_SET, 32'h5555_AAAA, 32'hAAAA_5555}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_GET, 32'h0000_0008, 32'h0000_0000}, PREDICTED, '{1'b0, 32'h0, 1'b0}},
        '{'{ACT_GET, 32'h5555_AAAA, 32'h0000_0000}, PREDICTED, '{1'b0, 32'h0, 1'b0}}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_req i_req;
    logic o_valid;
    logic i_ready;
    t_rsp o_rsp;

    lru_key_value_cache #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    // ------------------------------------------------------------------
    // Predictor state: a mirror of the cache contents and recency order.
    // Age 0 is the most recently used; ages of empty slots are ignored.
    // ------------------------------------------------------------------
    logic                    slot_valid [CAPACITY];
    logic signed [KEY_W-1:0] slot_key   [CAPACITY];
    logic signed [VAL_W-1:0] slot_value [CAPACITY];
    int                      slot_age   [CAPACITY];

    t_rsp pending_rsps [$];     // responses owed by the block, oldest first
    int   mismatches  = 0;
    int   cycle_count = 0;
    bit   hold_off_req = 1'b0;  // asks the receiver for one long stall

    // Slot becomes most recent; everything younger than it ages by one.
    function automatic void promote_slot(int idx);
        for (int i = 0; i < CAPACITY; i++) begin
            if (i != idx && slot_valid[i] && slot_age[i] < slot_age[idx])
                slot_age[i]++;
        end
        slot_age[idx] = 0;
    endfunction

    // Applies one request to the mirror and returns the response it owes.
    function automatic t_rsp cache_access(t_req r);
        int   idx = -1;
        t_rsp res;
        // lowest matching slot wins
        for (int i = 0; i < CAPACITY; i++) begin
            if (idx < 0 && slot_valid[i] && slot_key[i] == r.key)
                idx = i;
        end
        res.hit        = (idx >= 0);
        res.read_value = '0;
        res.evicted    = 1'b0;

        if (r.action == ACT_GET) begin
            if (idx >= 0) begin
                res.read_value = slot_value[idx];
                promote_slot(idx);
            end else begin
                res.read_value = MISS_VALUE;
            end
            return res;
        end

        if (idx >= 0) begin
            slot_value[idx] = r.value;
            promote_slot(idx);
            return res;
        end

        // absent key: lowest free slot, else evict the oldest
        for (int i = 0; i < CAPACITY; i++) begin
            if (idx < 0 && !slot_valid[i])
                idx = i;
        end
        if (idx < 0) begin
            idx = 0;
            for (int i = 1; i < CAPACITY; i++) begin
                if (slot_age[i] > slot_age[idx])
                    idx = i;
            end
            res.evicted = 1'b1;
            promote_slot(idx);
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_valid[i])
                    slot_age[i]++;
            end
            slot_age[idx]   = 0;
            slot_valid[idx] = 1'b1;
        end
        slot_key[idx]   = r.key;
        slot_value[idx] = r.value;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d responses still owed", $time, pending_rsps.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Offers one request and holds it until the block takes it;
    // the predictor runs at the accepting edge, so its order is the block's.
    // A zero gap keeps valid high straight into the next request.
    // ------------------------------------------------------------------
    task automatic send_request(input t_req r, input bit typed, input t_rsp typed_rsp,
                                input int gap);
        t_rsp predicted;
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        predicted = cache_access(r);
        pending_rsps.push_back(typed ? typed_rsp : predicted);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (pending_rsps.size() != 0);
    endtask

    initial begin
        logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
        t_req r;
        bit   sender_idles;
        int   gap;

        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_req   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            slot_valid[i] = 1'b0;
            slot_age[i]   = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, back to back with the odd gap
        foreach (plan[n])
            send_request(plan[n].req, plan[n].typed, plan[n].rsp, (n % 5 == 4) ? 3 : 0);

        // random gets and sets; a small key pool keeps hits and evictions common
        sender_idles = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 100 == 0) begin
                for (int k = 0; k < POOL_SIZE; k++)
                    key_pool[k] = $urandom;
            end
            if (n % 50 == 0)
                sender_idles = 1'($urandom_range(0, 1));

            r.action = $urandom_range(0, 1) ? ACT_SET : ACT_GET;
            if ($urandom_range(0, 9) == 0)
                r.key = $urandom;      // almost certainly a miss or a fresh insert
            else
                r.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            r.value = $urandom;

            // receiver sits still while requests keep coming: the block backs up
            if (n == 300)
                hold_off_req = 1'b1;
            // let everything in flight come out before carrying on
            if (n == 600) begin
                i_valid <= 1'b0;
                wait_drained();
            end

            gap = sender_idles ? $urandom_range(0, 16) : 0;
            send_request(r, PREDICTED, '0, gap);
        end

        i_valid <= 1'b0;
        wait_drained();
        repeat (4) @(posedge i_clk);   // catch any stray response

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver. Draws a stall per response; idles in stretches chosen at random.
    // ------------------------------------------------------------------
    initial begin
        int  stall;
        int  taken;
        bit  receiver_idles;

        i_ready        = 1'b0;
        taken          = 0;
        receiver_idles = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (taken % 50 == 0)
                receiver_idles = 1'($urandom_range(0, 1));
            stall = receiver_idles ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid)
                @(posedge i_clk);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Response checker: every accepted response against the oldest owed one.
    // Samples pre-edge values, so it sees what the handshake saw.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp owed;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_rsps.size() == 0) begin
                $display("%0t: unexpected response, expected none, got hit=%b value=%h evicted=%b",
                         $time, o_rsp.hit, o_rsp.read_value, o_rsp.evicted);
                mismatches++;
            end else begin
                owed = pending_rsps.pop_front();
                if (o_rsp.hit !== owed.hit) begin
                    $display("%0t: hit mismatch, expected %b, got %b",
                             $time, owed.hit, o_rsp.hit);
                    mismatches++;
                end
                if (o_rsp.read_value !== owed.read_value) begin
                    $display("%0t: read_value mismatch, expected %h, got %h",
                             $time, owed.read_value, o_rsp.read_value);
                    mismatches++;
                end
                if (o_rsp.evicted !== owed.evicted) begin
                    $display("%0t: evicted mismatch, expected %b, got %b",
                             $time, owed.evicted, o_rsp.evicted);
                    mismatches++;
                end
            end
        end
    end

endmodule
